/* sv/bnir_pkg.sv */
// Package for the image resizer core: transaction types, register indexes and blend arithmetic.
`timescale 1ns / 1ps
`default_nettype none

package bnir_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 3'd4;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    typedef struct packed {
        logic       action;
        logic [9:0] coord_x;
        logic [9:0] coord_y;
        logic [7:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       clamped;
    } t_out_item;

    // floor((a*(256-f) + b*f) / 256)
    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] f);
        logic [8:0]  wa;
        logic [16:0] sum;
        begin
            wa    = 9'd256 - {1'b0, f};
            sum   = 17'({8'd0, a} * {8'd0, wa}) + 17'({9'd0, b} * {9'd0, f});
            // a zero weight passes the first pixel untouched, whatever the second holds
            blend = (f == 8'd0) ? a : sum[15:8];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/bilinear_nearest_image_resizer_core.sv */
// Top level of the image resizer core: source image store, coordinate mapping and blend pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Resamples an 8-bit grayscale source image held on chip. A load transaction writes one
// source pixel and gives no result; a request transaction maps a target coordinate through
// the UQ8.16 steps, clamps it to the image and returns one pixel, nearest or bilinear.
// One transaction of either kind is accepted every cycle while o_in_stall is low. The source
// image sits in four banks split by column and row parity, each ceil(MAX_SRC_SIDE/2)^2 entries
// with one read and one write port, so the four neighbours of a request are fetched together.
// A request passes through the four-stage pipeline (product, address, memory read, horizontal
// blend), and its vertical blend is written into an eight-entry output queue. o_in_stall rises
// only when eight requests are outstanding or queued, i.e. when the downstream side holds
// i_out_stall for long enough. Unwritten pixels read as arbitrary values.
module bilinear_nearest_image_resizer_core #(
    parameter int MAX_SRC_SIDE = 256,
    parameter int MAX_DST_SIDE = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bnir_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bnir_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire bnir_pkg::t_in_item              i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output bnir_pkg::t_out_item                  o_out_data
);

    localparam int XW          = (MAX_SRC_SIDE > 1) ? $clog2(MAX_SRC_SIDE) : 1;
    localparam int HALF        = (MAX_SRC_SIDE + 1) / 2;
    localparam int BANK_DEPTH  = HALF * HALF;
    localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PW          = 34;
    localparam int IPW         = PW - FRAC_BITS;
    localparam int CW          = (IPW > XW) ? IPW : XW;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTRW        = $clog2(FIFO_DEPTH);
    localparam int OCW         = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic          action;
        logic          ld_ok;
        logic [XW-1:0] lx;
        logic [XW-1:0] ly;
        logic [7:0]    pix;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
    } t_s1;

    typedef struct packed {
        logic                req;
        logic                clamp;
        logic [7:0]          fx;
        logic [7:0]          fy;
        logic                xi0;
        logic                xn0;
        logic                yi0;
        logic                yn0;
        logic [3:0][AW-1:0]  raddr;
        logic [3:0]          we;
        logic [AW-1:0]       waddr;
        logic [7:0]          wpix;
    } t_s2;

    typedef struct packed {
        logic       clamp;
        logic [7:0] fx;
        logic [7:0] fy;
        logic       xi0;
        logic       xn0;
        logic       yi0;
        logic       yn0;
    } t_s3;

    typedef struct packed {
        logic       clamp;
        logic [7:0] top;
        logic [7:0] bot;
        logic [7:0] fy;
    } t_s4;

    function automatic logic [XW-1:0] f_last(input logic [8:0] s);
        logic [31:0] e;
        begin
            e = 32'(s);
            if (e == 32'd0) begin
                e = 32'd1;
            end else if (e > 32'(MAX_SRC_SIDE)) begin
                e = 32'(MAX_SRC_SIDE);
            end
            f_last = XW'(e - 32'd1);
        end
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [XW-1:0] x, input logic [XW-1:0] y);
        logic [31:0] row;
        logic [31:0] col;
        begin
            row    = 32'(y) >> 1;
            col    = 32'(x) >> 1;
            f_addr = AW'(row * 32'(HALF) + col);
        end
    endfunction

    // configuration; the sides are held as the derived last index per axis
    logic [XW-1:0] r_last_x;
    logic [XW-1:0] r_last_y;
    logic [23:0]   r_h_step;
    logic [23:0]   r_v_step;
    logic          r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= f_last(9'd256);
            r_last_y <= f_last(9'd256);
            r_h_step <= 24'h010000;
            r_v_step <= 24'h010000;
            r_mode   <= bnir_pkg::MODE_BILINEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bnir_pkg::REG_SRC_WIDTH:   r_last_x <= f_last(i_cfg_data[8:0]);
                bnir_pkg::REG_SRC_HEIGHT:  r_last_y <= f_last(i_cfg_data[8:0]);
                bnir_pkg::REG_H_STEP:      r_h_step <= i_cfg_data;
                bnir_pkg::REG_V_STEP:      r_v_step <= i_cfg_data;
                bnir_pkg::REG_INTERP_MODE: r_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // accept and scale
    logic        w_in_acc;
    logic [31:0] w_cx32;
    logic [31:0] w_cy32;
    logic [9:0]  w_cx_sat;
    logic [9:0]  w_cy_sat;
    t_s1         n_s1;
    t_s1         r_s1;
    logic        r_v1;
    logic [OCW-1:0] r_occ;

    assign o_in_stall = (r_occ >= OCW'(FIFO_DEPTH));
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        w_cx32 = 32'(i_in_data.coord_x);
        w_cy32 = 32'(i_in_data.coord_y);
        w_cx_sat = (w_cx32 >= 32'(MAX_DST_SIDE)) ? 10'(MAX_DST_SIDE - 1) : i_in_data.coord_x;
        w_cy_sat = (w_cy32 >= 32'(MAX_DST_SIDE)) ? 10'(MAX_DST_SIDE - 1) : i_in_data.coord_y;
        n_s1.action = i_in_data.action;
        n_s1.ld_ok  = (w_cx32 < 32'(MAX_SRC_SIDE)) && (w_cy32 < 32'(MAX_SRC_SIDE));
        n_s1.lx     = w_cx32[XW-1:0];
        n_s1.ly     = w_cy32[XW-1:0];
        n_s1.pix    = i_in_data.pixel_in;
        n_s1.px     = PW'(w_cx_sat) * PW'(r_h_step);
        n_s1.py     = PW'(w_cy_sat) * PW'(r_v_step);
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // map to source position, clamp, form bank addresses
    logic [PW-1:0] w_shx;
    logic [PW-1:0] w_shy;
    logic [CW-1:0] w_ipx;
    logic [CW-1:0] w_ipy;
    logic [FRAC_BITS-1:0] w_frx;
    logic [FRAC_BITS-1:0] w_fry;
    logic          w_clx;
    logic          w_cly;
    logic [XW-1:0] w_xi;
    logic [XW-1:0] w_yi;
    logic [XW-1:0] w_xn;
    logic [XW-1:0] w_yn;
    logic [XW-1:0] w_xsel [2];
    logic [XW-1:0] w_ysel [2];
    logic          w_s1_req;
    t_s2           n_s2;
    t_s2           r_s2;
    logic          r_v2;

    always_comb begin
        w_s1_req = r_v1 && (r_s1.action == bnir_pkg::ACT_REQUEST);
        w_shx = r_s1.px >> FRAC_BITS;
        w_shy = r_s1.py >> FRAC_BITS;
        w_ipx = CW'(w_shx);
        w_ipy = CW'(w_shy);
        w_frx = r_s1.px[FRAC_BITS-1:0];
        w_fry = r_s1.py[FRAC_BITS-1:0];
        w_clx = (w_ipx > CW'(r_last_x)) || ((w_ipx == CW'(r_last_x)) && (w_frx != '0));
        w_cly = (w_ipy > CW'(r_last_y)) || ((w_ipy == CW'(r_last_y)) && (w_fry != '0));
        w_xi  = w_clx ? r_last_x : w_ipx[XW-1:0];
        w_yi  = w_cly ? r_last_y : w_ipy[XW-1:0];
        w_xn  = (w_xi < r_last_x) ? w_xi + XW'(1) : r_last_x;
        w_yn  = (w_yi < r_last_y) ? w_yi + XW'(1) : r_last_y;
        for (int p = 0; p < 2; p++) begin
            w_xsel[p] = (w_xi[0] == p[0]) ? w_xi : w_xn;
            w_ysel[p] = (w_yi[0] == p[0]) ? w_yi : w_yn;
        end

        n_s2.req   = w_s1_req;
        n_s2.clamp = w_clx || w_cly;
        // nearest mode is the same datapath with both weights forced to zero
        n_s2.fx    = (w_clx || r_mode == bnir_pkg::MODE_NEAREST) ?
                     8'd0 : w_frx[FRAC_BITS-1 -: 8];
        n_s2.fy    = (w_cly || r_mode == bnir_pkg::MODE_NEAREST) ?
                     8'd0 : w_fry[FRAC_BITS-1 -: 8];
        n_s2.xi0   = w_xi[0];
        n_s2.xn0   = w_xn[0];
        n_s2.yi0   = w_yi[0];
        n_s2.yn0   = w_yn[0];
        for (int b = 0; b < 4; b++) begin
            n_s2.raddr[b] = f_addr(w_xsel[b % 2], w_ysel[b / 2]);
            n_s2.we[b]    = r_v1 && (r_s1.action == bnir_pkg::ACT_LOAD) && r_s1.ld_ok &&
                            ({r_s1.ly[0], r_s1.lx[0]} == 2'(b));
        end
        n_s2.waddr = f_addr(r_s1.lx, r_s1.ly);
        n_s2.wpix  = r_s1.pix;
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    // parity banks: write of a load and read of a request happen at the same stage,
    // so transactions keep their order without forwarding
    logic [7:0] r_rd [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [7:0] mem [BANK_DEPTH];
        always_ff @(posedge i_clk) begin
            if (r_v2 && r_s2.we[b]) begin
                mem[r_s2.waddr] <= r_s2.wpix;
            end
            r_rd[b] <= mem[r_s2.raddr[b]];
        end
    end

    t_s3  r_s3;
    logic r_v3;

    always_ff @(posedge i_clk) begin
        r_s3.clamp <= r_s2.clamp;
        r_s3.fx    <= r_s2.fx;
        r_s3.fy    <= r_s2.fy;
        r_s3.xi0   <= r_s2.xi0;
        r_s3.xn0   <= r_s2.xn0;
        r_s3.yi0   <= r_s2.yi0;
        r_s3.yn0   <= r_s2.yn0;
    end

    // horizontal blend of both rows
    t_s4  n_s4;
    t_s4  r_s4;
    logic r_v4;

    always_comb begin
        n_s4.clamp = r_s3.clamp;
        n_s4.fy    = r_s3.fy;
        n_s4.top   = bnir_pkg::blend(r_rd[{r_s3.yi0, r_s3.xi0}], r_rd[{r_s3.yi0, r_s3.xn0}],
                                     r_s3.fx);
        n_s4.bot   = bnir_pkg::blend(r_rd[{r_s3.yn0, r_s3.xi0}], r_rd[{r_s3.yn0, r_s3.xn0}],
                                     r_s3.fx);
    end

    always_ff @(posedge i_clk) begin
        r_s4 <= n_s4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= w_in_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_s2.req;
            r_v4 <= r_v3;
        end
    end

    // vertical blend straight into the output queue
    bnir_pkg::t_out_item r_fifo [FIFO_DEPTH];
    bnir_pkg::t_out_item w_res;
    logic [PTRW-1:0]     r_wr_ptr;
    logic [PTRW-1:0]     r_rd_ptr;
    logic [OCW-1:0]      r_cnt;
    logic                w_push;
    logic                w_pop;
    logic                w_acc_req;

    always_comb begin
        w_res.pixel_out = bnir_pkg::blend(r_s4.top, r_s4.bot, r_s4.fy);
        w_res.clamped   = r_s4.clamp;
    end

    assign w_push    = r_v4;
    assign w_pop     = o_out_valid && !i_out_stall;
    assign w_acc_req = w_in_acc && (i_in_data.action == bnir_pkg::ACT_REQUEST);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_occ    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTRW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTRW'(1);
            end
            r_cnt <= r_cnt + OCW'(w_push) - OCW'(w_pop);
            // occupancy counts requests in flight plus results queued
            r_occ <= r_occ + OCW'(w_acc_req) - OCW'(w_pop);
        end
    end

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCW'(FIFO_DEPTH))
        else $error("occupancy above queue depth");

    a_occ_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == r_cnt + OCW'($countones({r_v1 && r_s1.action == bnir_pkg::ACT_REQUEST,
                                          r_v2 && r_s2.req, r_v3, r_v4})))
        else $error("occupancy does not match requests in flight and queued");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_cnt < OCW'(FIFO_DEPTH)) || w_pop)
        else $error("result pushed into a full queue");

    a_clamp_zero_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_clx) |=> (r_s2.fx == 8'd0))
        else $error("clamped column carries a nonzero weight");
`endif

endmodule

`default_nettype wire

/* test/tb_bilinear_nearest_image_resizer_core.sv */
// Testbench for the image resizer core: loads and resample requests against a local predictor.
`timescale 1ns / 1ps

module tb_bilinear_nearest_image_resizer_core;

    typedef struct packed {
        logic [7:0] idx;
        logic [7:0] frac;
        logic       over;
    } t_axis_pos;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [bnir_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [bnir_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    bnir_pkg::t_in_item              i_in_data  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    bnir_pkg::t_out_item             o_out_data;

    // Local copy of the scaler settings and the source image
    logic [8:0]  scale_w    = 9'd256;
    logic [8:0]  scale_h    = 9'd256;
    logic [23:0] scale_hs   = 24'd65536;
    logic [23:0] scale_vs   = 24'd65536;
    logic        scale_mode = bnir_pkg::MODE_BILINEAR;
    logic [7:0]  src_img     [0:65535];
    bit          src_written [0:65535];

    bnir_pkg::t_out_item pixel_queue[$];
    bnir_pkg::t_out_item want_item;

    bit          idling = 1'b1;
    int unsigned stall_left    = 0;
    int unsigned items_sent    = 0;
    int unsigned requests_sent = 0;
    int unsigned loads_done    = 0;
    int unsigned loads_ignored = 0;
    int unsigned settings_used = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;

    bilinear_nearest_image_resizer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_side(input logic [8:0] side);
        if (side == 9'd0) begin
            return 1;
        end
        if (side > 9'd256) begin
            return 256;
        end
        return 32'(side);
    endfunction

    // Scale a target coordinate to a source index and 8-bit weight, pinning to the edge
    function automatic t_axis_pos scale_axis(input logic [9:0] coord, input logic [23:0] step,
                                             input logic [8:0] side);
        logic [33:0] pos;
        logic [17:0] whole;
        int unsigned last;
        t_axis_pos   ap;
        last  = eff_side(side) - 1;
        // coordinates above 1023 cannot occur, so no saturation is needed
        pos   = {24'd0, coord} * {10'd0, step};
        whole = pos[33:16];
        if (whole > last || (whole == last && pos[15:0] != 16'd0)) begin
            ap.idx  = last[7:0];
            ap.frac = 8'd0;
            ap.over = 1'b1;
        end else begin
            ap.idx  = whole[7:0];
            ap.frac = pos[15:8];
            ap.over = 1'b0;
        end
        return ap;
    endfunction

    function automatic logic [7:0] next_index(input logic [7:0] idx, input logic [8:0] side);
        int unsigned last;
        last = eff_side(side) - 1;
        return (idx < last) ? idx + 8'd1 : last[7:0];
    endfunction

    function automatic logic [7:0] mix_pair(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] f);
        int unsigned acc;
        acc = a * (256 - f) + b * f;
        return acc[15:8];
    endfunction

    function automatic bnir_pkg::t_out_item resample_pixel(input logic [9:0] cx,
                                                           input logic [9:0] cy);
        t_axis_pos           ax;
        t_axis_pos           ay;
        logic [7:0]          xn;
        logic [7:0]          yn;
        logic [7:0]          upper;
        logic [7:0]          lower;
        bnir_pkg::t_out_item res;
        ax = scale_axis(cx, scale_hs, scale_w);
        ay = scale_axis(cy, scale_vs, scale_h);
        xn = next_index(ax.idx, scale_w);
        yn = next_index(ay.idx, scale_h);
        if (scale_mode == bnir_pkg::MODE_NEAREST) begin
            res.pixel_out = src_img[{ay.idx, ax.idx}];
        end else begin
            upper = mix_pair(src_img[{ay.idx, ax.idx}], src_img[{ay.idx, xn}], ax.frac);
            lower = mix_pair(src_img[{yn, ax.idx}], src_img[{yn, xn}], ax.frac);
            res.pixel_out = mix_pair(upper, lower, ay.frac);
        end
        res.clamped = ax.over | ay.over;
        return res;
    endfunction

    function automatic bnir_pkg::t_in_item make_item(input logic act, input logic [9:0] x,
                                                     input logic [9:0] y, input logic [7:0] p);
        bnir_pkg::t_in_item it;
        it.action   = act;
        it.coord_x  = x;
        it.coord_y  = y;
        it.pixel_in = p;
        return it;
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Step that spans the source over span target pixels, sometimes overshooting
    function automatic logic [23:0] pick_step(input logic [8:0] side, input int unsigned span);
        int unsigned base;
        base = ((eff_side(side) - 1) << 16) / span;
        case ($urandom_range(0, 7))
            0: return 24'($urandom_range(0, 24'hFFFFFF));
            1: return 24'(base + $urandom_range(1, 16'hFFFF));
            default: return 24'(base);
        endcase
    endfunction

    function automatic logic [9:0] rand_coord(input int unsigned span);
        case ($urandom_range(0, 15))
            0: return 10'd1023;
            1: return 10'd0;
            default: return 10'($urandom_range(0, span));
        endcase
    endfunction

    task automatic note_accepted(input bnir_pkg::t_in_item it);
        items_sent++;
        if (it.action == bnir_pkg::ACT_LOAD) begin
            if (it.coord_x < 10'd256 && it.coord_y < 10'd256) begin
                src_img[{it.coord_y[7:0], it.coord_x[7:0]}]     = it.pixel_in;
                src_written[{it.coord_y[7:0], it.coord_x[7:0]}] = 1'b1;
                loads_done++;
            end else begin
                loads_ignored++;
            end
        end else begin
            pixel_queue = {pixel_queue, resample_pixel(it.coord_x, it.coord_y)};
            requests_sent++;
        end
    endtask

    // Called just after a rising edge; returns at the edge that took the transaction
    task automatic send_item(input bnir_pkg::t_in_item it);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        note_accepted(it);
    endtask

    task automatic load_pixel(input logic [9:0] x, input logic [9:0] y, input logic [7:0] p);
        send_item(make_item(bnir_pkg::ACT_LOAD, x, y, p));
    endtask

    task automatic fill_pixel(input logic [7:0] x, input logic [7:0] y);
        if (!src_written[{y, x}]) begin
            load_pixel({2'b00, x}, {2'b00, y}, rand_pixel());
        end
    endtask

    // Load any neighbour not yet written, then issue the request
    task automatic request_pixel(input logic [9:0] cx, input logic [9:0] cy);
        t_axis_pos  ax;
        t_axis_pos  ay;
        logic [7:0] xn;
        logic [7:0] yn;
        ax = scale_axis(cx, scale_hs, scale_w);
        ay = scale_axis(cy, scale_vs, scale_h);
        xn = next_index(ax.idx, scale_w);
        yn = next_index(ay.idx, scale_h);
        fill_pixel(ax.idx, ay.idx);
        fill_pixel(xn, ay.idx);
        fill_pixel(ax.idx, yn);
        fill_pixel(xn, yn);
        send_item(make_item(bnir_pkg::ACT_REQUEST, cx, cy, 8'($urandom_range(0, 255))));
    endtask

    task automatic drain_pipeline();
        i_in_valid <= 1'b0;
        while (pixel_queue.size() != 0) @(posedge i_clk);
        // trailing loads give no result; let them retire
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bnir_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bnir_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_scaler(input logic [8:0] w, input logic [8:0] h,
                                  input logic [23:0] hs, input logic [23:0] vs,
                                  input logic mode);
        drain_pipeline();
        write_reg(bnir_pkg::REG_SRC_WIDTH, {15'd0, w});
        write_reg(bnir_pkg::REG_SRC_HEIGHT, {15'd0, h});
        write_reg(bnir_pkg::REG_H_STEP, hs);
        write_reg(bnir_pkg::REG_V_STEP, vs);
        write_reg(bnir_pkg::REG_INTERP_MODE, {23'd0, mode});
        i_cfg_we   <= 1'b0;
        scale_w    = w;
        scale_h    = h;
        scale_hs   = hs;
        scale_vs   = vs;
        scale_mode = mode;
        settings_used++;
    endtask

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
        end
    endtask

    // Result checker and downstream stall generator
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pixel_queue.size() == 0) begin
                note_mismatch("unexpected result, pixel", -1, o_out_data.pixel_out);
            end else begin
                want_item = pixel_queue.pop_front();
                if (o_out_data.pixel_out !== want_item.pixel_out) begin
                    note_mismatch("pixel_out", want_item.pixel_out, o_out_data.pixel_out);
                end
                if (o_out_data.clamped !== want_item.clamped) begin
                    note_mismatch("clamped", want_item.clamped, o_out_data.clamped);
                end
            end
            stall_left = idling ? $urandom_range(0, 4) : 0;
            i_out_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= (stall_left != 0);
        end
    end

    // Settings after reset: unit steps, bilinear, full-size image
    task automatic test_reset_defaults();
        settings_used++;
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd255, 10'd255);
        request_pixel(10'd1023, 10'd3);
    endtask

    // Loads outside the store must not alias onto pixel (0,0)
    task automatic test_ignored_loads();
        load_pixel(10'd256, 10'd0, ~src_img[0]);
        load_pixel(10'd0, 10'd256, ~src_img[0]);
        load_pixel(10'd1023, 10'd1023, ~src_img[0]);
        request_pixel(10'd0, 10'd0);
    endtask

    task automatic test_nearest_mode();
        program_scaler(9'd5, 9'd3, 24'h018000, 24'h00C000, bnir_pkg::MODE_NEAREST);
        request_pixel(10'd1, 10'd1);
        request_pixel(10'd3, 10'd1);
        request_pixel(10'd0, 10'd3);
    endtask

    task automatic test_bilinear_mode();
        program_scaler(9'd5, 9'd3, 24'h018000, 24'h00C000, bnir_pkg::MODE_BILINEAR);
        load_pixel(10'd1, 10'd0, 8'd255);
        load_pixel(10'd2, 10'd0, 8'd0);
        load_pixel(10'd1, 10'd1, 8'd0);
        load_pixel(10'd2, 10'd1, 8'd255);
        request_pixel(10'd1, 10'd1);
        request_pixel(10'd2, 10'd2);
        request_pixel(10'd4, 10'd4);
    endtask

    // Zero and oversize sides, zero and full-scale steps
    task automatic test_side_extremes();
        program_scaler(9'd0, 9'd300, 24'hFFFFFF, 24'd0, bnir_pkg::MODE_BILINEAR);
        request_pixel(10'd0, 10'd0);
        request_pixel(10'd1, 10'd9);
        program_scaler(9'd300, 9'd0, 24'd0, 24'hFFFFFF, bnir_pkg::MODE_NEAREST);
        request_pixel(10'd1023, 10'd0);
        request_pixel(10'd5, 10'd1);
    endtask

    task automatic test_random_traffic(input int unsigned target);
        int unsigned goal;
        int unsigned span_x;
        int unsigned span_y;
        int unsigned burst;
        int unsigned done;
        logic [8:0]  w;
        logic [8:0]  h;
        logic [9:0]  x;
        logic [9:0]  y;
        goal = items_sent + target;
        while (items_sent < goal) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = 9'($urandom_range(200, 511));
                    h = 9'($urandom_range(200, 511));
                end
                1: begin
                    w = 9'($urandom_range(0, 2));
                    h = 9'($urandom_range(0, 40));
                end
                default: begin
                    w = 9'($urandom_range(2, 16));
                    h = 9'($urandom_range(2, 16));
                end
            endcase
            span_x = ($urandom_range(0, 3) == 0) ?
                     $urandom_range(1, 1023) : $urandom_range(1, 64);
            span_y = ($urandom_range(0, 3) == 0) ?
                     $urandom_range(1, 1023) : $urandom_range(1, 64);
            program_scaler(w, h, pick_step(w, span_x), pick_step(h, span_y),
                           logic'($urandom_range(0, 1)));
            idling = ($urandom_range(0, 3) != 0);
            burst  = $urandom_range(40, 120);
            done   = 0;
            while (done < burst && items_sent < goal) begin
                if ($urandom_range(0, 9) < 7) begin
                    request_pixel(rand_coord(span_x), rand_coord(span_y));
                end else begin
                    if ($urandom_range(0, 1) == 0) begin
                        x = 10'($urandom_range(0, eff_side(scale_w) - 1));
                        y = 10'($urandom_range(0, eff_side(scale_h) - 1));
                    end else begin
                        x = 10'($urandom_range(0, 1023));
                        y = 10'($urandom_range(0, 1023));
                    end
                    load_pixel(x, y, rand_pixel());
                end
                done++;
            end
        end
        idling = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_ignored_loads();
        test_nearest_mode();
        test_bilinear_mode();
        test_side_extremes();
        test_random_traffic(1320);
        drain_pipeline();
        $display("checked %0d resampled pixels under %0d scaler settings", results_seen,
                 settings_used);
        $display("stored %0d source pixels, dropped %0d loads outside the image store",
                 loads_done, loads_ignored);
        if (mismatches == 0 && pixel_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
